// ----- design/pbsrf_pkg.sv -----
// ----------------------------------------------------------------------------
// pbsrf_pkg
// Shared types and constants for the packet blocklist and SYN rate filter.
// ----------------------------------------------------------------------------
package pbsrf_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;
	localparam int LRU_W      = 3;

	localparam logic [1:0] OP_PACKET = 2'd0;
	localparam logic [1:0] OP_ADD    = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_GAME_PORT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYN_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd2;

	localparam logic [2:0] R_PASS      = 3'd0;
	localparam logic [2:0] R_BLOCK     = 3'd1;
	localparam logic [2:0] R_FLOOD     = 3'd2;
	localparam logic [2:0] R_MALFORMED = 3'd3;
	localparam logic [2:0] R_UNCOUNTED = 3'd4;

	localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
	localparam logic [7:0]  PROTO_TCP       = 8'd6;
	localparam logic [16:0] ETH_HDR_BYTES   = 17'd14;
	localparam logic [16:0] IP_HDR_BYTES    = 17'd20;
	localparam logic [16:0] TCP_HDR_BYTES   = 17'd20;
	localparam logic [3:0]  MIN_HDR_WORDS   = 4'd5;
	localparam logic [15:0] PRIV_PORT_LIMIT = 16'd1024;
	localparam logic [31:0] HASH_MULT       = 32'h9E37_79B1;
	localparam logic [32:0] SYN_COUNT_MAX   = 33'h1_0000_0000;

	localparam int F_FIN = 0;
	localparam int F_SYN = 1;
	localparam int F_RST = 2;
	localparam int F_PSH = 3;
	localparam int F_ACK = 4;
	localparam int F_URG = 5;

	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] now_ns;
		logic [15:0] frame_len;
		logic [15:0] ethertype;
		logic [3:0]  ip_ihl;
		logic [7:0]  ip_protocol;
		logic [31:0] src_addr;
		logic [5:0]  tcp_flag_bits;
		logic [3:0]  tcp_data_offset;
		logic [15:0] tcp_src_port;
		logic [15:0] tcp_dst_port;
		logic [63:0] ban_expiry_ns;
	} in_t;

	typedef struct packed {
		logic        drop;
		logic [2:0]  reason;
		logic [63:0] stat_value;
		logic        table_full;
	} out_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] key;
		logic [63:0] expiry;
	} blk_ent_t;

	typedef struct packed {
		logic             valid;
		logic [31:0]      key;
		logic [63:0]      start;
		logic [32:0]      count;
		logic [LRU_W-1:0] rank;
	} syn_ent_t;

	typedef struct packed {
		logic accept;
		logic clear;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_free;
	} sts_t;

endpackage

// ----- design/pbsrf_dp.sv -----
// ----------------------------------------------------------------------------
// pbsrf_dp
// Datapath: set hashing, table memories, lookup, verdict and counters.
// ----------------------------------------------------------------------------
module pbsrf_dp #(
	parameter int BLOCK_ENTRIES = 4096,
	parameter int SYN_ENTRIES   = 1024,
	parameter int TABLE_WAYS    = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pbsrf_pkg::cmd_t                    cmd,
	output pbsrf_pkg::sts_t                    sts,
	input  pbsrf_pkg::in_t                     item,
	output pbsrf_pkg::out_t                    result,
	output logic                               result_valid,
	input  logic                               result_ready,
	input  logic                               cfg_we,
	input  logic [pbsrf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pbsrf_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import pbsrf_pkg::*;

	localparam int BLOCK_SETS = BLOCK_ENTRIES / TABLE_WAYS;
	localparam int SYN_SETS   = SYN_ENTRIES / TABLE_WAYS;
	localparam int BSET_W     = $clog2(BLOCK_SETS);
	localparam int SSET_W     = $clog2(SYN_SETS);
	localparam int CLR_ROWS   = (BLOCK_SETS > SYN_SETS) ? BLOCK_SETS : SYN_SETS;
	localparam int CLR_W      = $clog2(CLR_ROWS);
	localparam int WAY_W      = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
	localparam int ORD_W      = LRU_W + 1;
	localparam logic [31:0] BLK_SETS32  = 32'(BLOCK_SETS);
	localparam logic [31:0] SYN_SETS32  = 32'(SYN_SETS);
	localparam logic [31:0] BLK_RECIP   = 32'((64'd1 << 32) / BLOCK_SETS);
	localparam logic [31:0] SYN_RECIP   = 32'((64'd1 << 32) / SYN_SETS);

	typedef blk_ent_t [TABLE_WAYS-1:0] blk_row_t;
	typedef syn_ent_t [TABLE_WAYS-1:0] syn_row_t;

	in_t         in_q;
	logic [15:0] gp_q;
	logic [31:0] lim_q;
	logic [63:0] win_q;

	// set index: multiplicative hash, then remainder by reciprocal multiply
	logic [31:0] h_s1, hm_c, hm_s2, hm_s3, bq_s2, sq_s2, bp_s3, sp_s3;
	logic [63:0] bprod, sprod;
	logic [31:0] br, sr, bfix, sfix;
	logic [BSET_W-1:0] bidx_q;
	logic [SSET_W-1:0] sidx_q;

	assign hm_c  = h_s1 ^ (h_s1 >> 16);
	assign bprod = {32'd0, hm_c} * {32'd0, BLK_RECIP};
	assign sprod = {32'd0, hm_c} * {32'd0, SYN_RECIP};
	assign br    = hm_s3 - bp_s3;
	assign sr    = hm_s3 - sp_s3;
	assign bfix  = (br >= BLK_SETS32) ? br - BLK_SETS32 : br;
	assign sfix  = (sr >= SYN_SETS32) ? sr - SYN_SETS32 : sr;

	always_ff @(posedge clk) begin
		h_s1   <= in_q.src_addr * HASH_MULT;
		hm_s2  <= hm_c;
		bq_s2  <= bprod[63:32];
		sq_s2  <= sprod[63:32];
		hm_s3  <= hm_s2;
		bp_s3  <= bq_s2 * BLK_SETS32;
		sp_s3  <= sq_s2 * SYN_SETS32;
		bidx_q <= bfix[BSET_W-1:0];
		sidx_q <= sfix[SSET_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			in_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_q  <= '0;
			lim_q <= '0;
			win_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GAME_PORT: gp_q  <= cfg_data[15:0];
				CFG_SYN_LIMIT: lim_q <= cfg_data[31:0];
				CFG_WINDOW:    win_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// table memories, one set per row
	blk_row_t blk_mem [BLOCK_SETS];
	syn_row_t syn_mem [SYN_SETS];
	blk_row_t brow_q, bnew;
	syn_row_t srow_q, snew;
	logic              blk_wr, syn_wr, bwe, swe;
	logic [BSET_W-1:0] bwa;
	logic [SSET_W-1:0] swa;
	blk_row_t          bwd;
	syn_row_t          swd;
	logic [CLR_W-1:0]  clr_q;

	assign bwe = cmd.clear ? ({1'b0, clr_q} < (CLR_W+1)'(BLOCK_SETS)) : (cmd.commit & blk_wr);
	assign swe = cmd.clear ? ({1'b0, clr_q} < (CLR_W+1)'(SYN_SETS)) : (cmd.commit & syn_wr);
	assign bwa = cmd.clear ? clr_q[BSET_W-1:0] : bidx_q;
	assign swa = cmd.clear ? clr_q[SSET_W-1:0] : sidx_q;
	assign bwd = cmd.clear ? '0 : bnew;
	assign swd = cmd.clear ? '0 : snew;

	always_ff @(posedge clk) begin
		if (bwe) begin
			blk_mem[bwa] <= bwd;
		end
		brow_q <= blk_mem[bidx_q];
	end

	always_ff @(posedge clk) begin
		if (swe) begin
			syn_mem[swa] <= swd;
		end
		srow_q <= syn_mem[sidx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign sts.clr_last = (clr_q == CLR_W'(CLR_ROWS - 1));

	// way lookup
	logic             bhit_c, binv_c, shit_c, sinv_c, swasv_c;
	logic [WAY_W-1:0] bway_c, binvway_c, shway_c, sinvway_c, svict_c, sway_c;
	logic             bhit_q, binv_q, shit_q, swasv_q;
	logic [WAY_W-1:0] bway_q, binvway_q, sway_q;

	always_comb begin
		bhit_c    = 1'b0;
		binv_c    = 1'b0;
		bway_c    = '0;
		binvway_c = '0;
		shit_c    = 1'b0;
		sinv_c    = 1'b0;
		shway_c   = '0;
		sinvway_c = '0;
		svict_c   = '0;
		for (int w = TABLE_WAYS - 1; w >= 0; w--) begin
			if (brow_q[w].valid && brow_q[w].key == in_q.src_addr) begin
				bhit_c = 1'b1;
				bway_c = WAY_W'(w);
			end
			if (!brow_q[w].valid) begin
				binv_c    = 1'b1;
				binvway_c = WAY_W'(w);
			end
			if (srow_q[w].valid && srow_q[w].key == in_q.src_addr) begin
				shit_c  = 1'b1;
				shway_c = WAY_W'(w);
			end
			if (!srow_q[w].valid) begin
				sinv_c    = 1'b1;
				sinvway_c = WAY_W'(w);
			end
		end
		// oldest way, last one on a tie
		for (int w = 0; w < TABLE_WAYS; w++) begin
			if (srow_q[w].rank >= srow_q[svict_c].rank) begin
				svict_c = WAY_W'(w);
			end
		end
		sway_c  = shit_c ? shway_c : (sinv_c ? sinvway_c : svict_c);
		swasv_c = shit_c || !sinv_c;
	end

	always_ff @(posedge clk) begin
		bhit_q    <= bhit_c;
		binv_q    <= binv_c;
		bway_q    <= bway_c;
		binvway_q <= binvway_c;
		shit_q    <= shit_c;
		sway_q    <= sway_c;
		swasv_q   <= swasv_c;
	end

	// evaluation
	blk_ent_t    be;
	syn_ent_t    se;
	logic [32:0] cnt_next_c, cnt_next_q;
	logic        blocked_q, over_q, flood_q;
	logic        early_q, nontcp_q, trunc_q, gpoff_q, port_q, bad_q, synck_q;
	logic        fin, syn, rst, psh, ack, urg;

	assign be  = brow_q[bway_q];
	assign se  = srow_q[sway_q];
	assign fin = in_q.tcp_flag_bits[F_FIN];
	assign syn = in_q.tcp_flag_bits[F_SYN];
	assign rst = in_q.tcp_flag_bits[F_RST];
	assign psh = in_q.tcp_flag_bits[F_PSH];
	assign ack = in_q.tcp_flag_bits[F_ACK];
	assign urg = in_q.tcp_flag_bits[F_URG];
	assign cnt_next_c = (se.count >= SYN_COUNT_MAX) ? se.count : se.count + 1'b1;

	always_ff @(posedge clk) begin
		blocked_q  <= bhit_q && (be.expiry == 64'd0 || be.expiry > in_q.now_ns);
		over_q     <= (in_q.now_ns - se.start) > win_q;
		cnt_next_q <= cnt_next_c;
		flood_q    <= shit_q && (cnt_next_c > {1'b0, lim_q});
		early_q    <= ({1'b0, in_q.frame_len} < ETH_HDR_BYTES + IP_HDR_BYTES)
			|| in_q.ethertype != ETHERTYPE_IPV4 || in_q.ip_ihl < MIN_HDR_WORDS;
		nontcp_q   <= in_q.ip_protocol != PROTO_TCP;
		trunc_q    <= {1'b0, in_q.frame_len}
			< ETH_HDR_BYTES + TCP_HDR_BYTES + {11'd0, in_q.ip_ihl, 2'b00};
		gpoff_q    <= gp_q == 16'd0;
		port_q     <= in_q.tcp_dst_port == gp_q;
		bad_q      <= in_q.tcp_data_offset < MIN_HDR_WORDS || (!syn && !ack && !rst && !fin)
			|| (syn && fin) || (syn && rst) || (fin && psh && urg && !ack)
			|| (syn && !ack && in_q.tcp_src_port < PRIV_PORT_LIMIT);
		synck_q    <= syn && !ack;
	end

	// verdict and write-back rows
	logic             drop_c, full_c;
	logic [2:0]       reason_c;
	logic [ORD_W-1:0] old_rank;

	always_comb begin
		drop_c   = 1'b0;
		full_c   = 1'b0;
		reason_c = R_UNCOUNTED;
		blk_wr   = 1'b0;
		syn_wr   = 1'b0;
		bnew     = brow_q;
		snew     = srow_q;
		old_rank = swasv_q ? {1'b0, srow_q[sway_q].rank} : ORD_W'(TABLE_WAYS);
		for (int i = 0; i < TABLE_WAYS; i++) begin
			if (WAY_W'(i) != sway_q && srow_q[i].valid && {1'b0, srow_q[i].rank} < old_rank) begin
				snew[i].rank = srow_q[i].rank + 1'b1;
			end
		end
		snew[sway_q].rank = '0;
		if (shit_q) begin
			if (over_q) begin
				snew[sway_q].start = in_q.now_ns;
				snew[sway_q].count = 33'd1;
			end else begin
				snew[sway_q].count = cnt_next_q;
			end
		end else begin
			snew[sway_q].valid = 1'b1;
			snew[sway_q].key   = in_q.src_addr;
			snew[sway_q].start = in_q.now_ns;
			snew[sway_q].count = 33'd1;
		end
		case (in_q.operation)
			OP_ADD: begin
				if (bhit_q) begin
					bnew[bway_q].expiry = in_q.ban_expiry_ns;
					blk_wr = 1'b1;
				end else if (binv_q) begin
					bnew[binvway_q].valid  = 1'b1;
					bnew[binvway_q].key    = in_q.src_addr;
					bnew[binvway_q].expiry = in_q.ban_expiry_ns;
					blk_wr = 1'b1;
				end else begin
					full_c = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (bhit_q) begin
					bnew[bway_q].valid = 1'b0;
					blk_wr = 1'b1;
				end
			end
			OP_PACKET: begin
				if (early_q) begin
					reason_c = R_UNCOUNTED;
				end else if (blocked_q) begin
					drop_c   = 1'b1;
					reason_c = R_BLOCK;
				end else if (nontcp_q) begin
					reason_c = R_PASS;
				end else if (trunc_q) begin
					drop_c   = 1'b1;
					reason_c = R_MALFORMED;
				end else if (gpoff_q || !port_q) begin
					reason_c = R_PASS;
				end else if (bad_q) begin
					drop_c   = 1'b1;
					reason_c = R_MALFORMED;
				end else if (synck_q) begin
					syn_wr = 1'b1;
					if (shit_q && !over_q && flood_q) begin
						drop_c   = 1'b1;
						reason_c = R_FLOOD;
					end else begin
						reason_c = R_PASS;
					end
				end else begin
					reason_c = R_PASS;
				end
			end
			default: reason_c = R_UNCOUNTED;
		endcase
	end

	// counters and result register
	logic [63:0] stat_q [4];
	logic [63:0] stat_inc;
	logic        counted;
	logic        result_valid_q;
	out_t        result_q;

	assign counted  = reason_c <= R_MALFORMED;
	assign stat_inc = stat_q[reason_c[1:0]] + 64'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				stat_q[i] <= '0;
			end
		end else if (cmd.commit && counted) begin
			stat_q[reason_c[1:0]] <= stat_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			result_q.drop       <= drop_c;
			result_q.reason     <= reason_c;
			result_q.stat_value <= counted ? stat_inc : 64'd0;
			result_q.table_full <= full_c;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;
	assign sts.out_free = !result_valid_q || result_ready;

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> result_valid_q)
		else $error("result not raised after commit");
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.table_full |-> !result_q.drop
		&& result_q.reason == R_UNCOUNTED)
		else $error("refused add carries a drop verdict");
	a_drop_reason: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.drop |-> result_q.reason == R_BLOCK
		|| result_q.reason == R_FLOOD || result_q.reason == R_MALFORMED)
		else $error("drop with a passing reason");

endmodule

// ----- design/pbsrf_ctrl.sv -----
// ----------------------------------------------------------------------------
// pbsrf_ctrl
// Sequencer: table clearing after reset, request intake, commit timing.
// ----------------------------------------------------------------------------
module pbsrf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	output pbsrf_pkg::cmd_t cmd,
	input  pbsrf_pkg::sts_t sts
);
	import pbsrf_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_CLEAR  = 2'd1;
	localparam logic [1:0] ST_WAIT   = 2'd2;
	localparam logic [1:0] ST_COMMIT = 2'd3;
	// hash, table read, lookup and evaluation stages in the datapath
	localparam logic [2:0] WAIT_LAST = 3'd6;

	logic [1:0] state_q;
	logic [2:0] wait_q;

	assign item_ready = state_q == ST_IDLE;
	assign cmd.accept = item_valid && item_ready;
	assign cmd.clear  = state_q == ST_CLEAR;
	assign cmd.commit = state_q == ST_COMMIT && sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			wait_q  <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd.accept) begin
						state_q <= ST_WAIT;
						wait_q  <= '0;
					end
				end
				ST_WAIT: begin
					if (wait_q == WAIT_LAST) begin
						state_q <= ST_COMMIT;
					end else begin
						wait_q <= wait_q + 1'b1;
					end
				end
				ST_COMMIT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_accept_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == ST_WAIT && wait_q == 3'd0)
		else $error("request accepted without starting the sequence");
	a_clear_closed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !cmd.accept && !cmd.commit)
		else $error("activity during table clearing");
	a_commit_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> state_q == ST_IDLE)
		else $error("commit not followed by idle");

endmodule

// ----- design/packet_blocklist_syn_rate_filter.sv -----
// ----------------------------------------------------------------------------
// packet_blocklist_syn_rate_filter
// IPv4/TCP filter with a 4-way source blocklist and per-source SYN limiting.
// ----------------------------------------------------------------------------
// latency: from request accept to result valid a request passes the hash,
//   read, lookup, evaluate and commit stages of the hash and table pipeline
// throughput: one request at a time, a single table read-modify-write
//   per request; the commit waits while the result register is still full
// reset: after arst_n a clearing pass over max(block sets, syn sets) rows
//   (1024 by default) zeroes both tables; no request is taken meanwhile
module packet_blocklist_syn_rate_filter #(
	parameter int BLOCK_ENTRIES = 4096,
	parameter int SYN_ENTRIES   = 1024,
	parameter int TABLE_WAYS    = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  pbsrf_pkg::in_t                    item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output pbsrf_pkg::out_t                   result,
	input  logic                              cfg_we,
	input  logic [pbsrf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pbsrf_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pbsrf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pbsrf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	pbsrf_dp #(
		.BLOCK_ENTRIES (BLOCK_ENTRIES),
		.SYN_ENTRIES   (SYN_ENTRIES),
		.TABLE_WAYS    (TABLE_WAYS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item         (item),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

endmodule

// ----- tb/packet_blocklist_syn_rate_filter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_blocklist_syn_rate_filter_tb
// Drives packet headers and blocklist requests into the filter, predicts each
// verdict from a local model of both tables and the counters, and compares
// every result field by field. A directed table runs first, then random
// traffic over several register settings.
// ----------------------------------------------------------------------------
module packet_blocklist_syn_rate_filter_tb;
	import pbsrf_pkg::*;

	localparam int BLK_N = 4096;
	localparam int SYN_N = 1024;
	localparam int WAYS  = 4;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	in_t  item;
	logic result_valid;
	logic result_ready;
	out_t result;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	packet_blocklist_syn_rate_filter u_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	// local copy of registers and tables
	logic [15:0] prot_port;
	logic [31:0] syn_limit;
	logic [63:0] win_len_ns;
	bit          bl_valid [BLK_N];
	logic [31:0] bl_key   [BLK_N];
	logic [63:0] bl_exp   [BLK_N];
	bit          sy_valid [SYN_N];
	logic [31:0] sy_key   [SYN_N];
	logic [63:0] sy_start [SYN_N];
	logic [32:0] sy_count [SYN_N];
	int          sy_rank  [SYN_N];
	logic [63:0] reason_cnt [4];

	out_t verdict_q [$];
	int   mismatches;
	bit   quiet;
	bit   row_typed;
	out_t row_verdict;
	logic [63:0] now_clock;
	logic [31:0] pool [12];

	function automatic int unsigned set_index(logic [31:0] k, int sets);
		logic [31:0] h;
		h = k * 32'h9E37_79B1;
		h = h ^ (h >> 16);
		return h % sets;
	endfunction

	function automatic int bl_find(logic [31:0] k);
		int base;
		base = set_index(k, BLK_N / WAYS) * WAYS;
		for (int w = 0; w < WAYS; w++)
			if (bl_valid[base + w] && bl_key[base + w] == k)
				return base + w;
		return -1;
	endfunction

	function automatic void syn_promote(int base, int way, bit was_valid);
		int old;
		old = was_valid ? sy_rank[base + way] : WAYS;
		for (int w = 0; w < WAYS; w++)
			if (w != way && sy_valid[base + w] && sy_rank[base + w] < old)
				sy_rank[base + w]++;
		sy_rank[base + way] = 0;
	endfunction

	// true when the SYN goes over the per-source limit
	function automatic bit syn_flooding(logic [31:0] k, logic [63:0] now);
		int base;
		int victim;
		bit found;
		base = set_index(k, SYN_N / WAYS) * WAYS;
		victim = 0;
		found = 0;
		for (int w = 0; w < WAYS; w++) begin
			int e;
			e = base + w;
			if (sy_valid[e] && sy_key[e] == k) begin
				syn_promote(base, w, 1'b1);
				if (now - sy_start[e] > win_len_ns) begin
					sy_start[e] = now;
					sy_count[e] = 33'd1;
					return 1'b0;
				end
				if (sy_count[e] < SYN_COUNT_MAX)
					sy_count[e]++;
				return sy_count[e] > {1'b0, syn_limit};
			end
		end
		for (int w = 0; w < WAYS; w++)
			if (!found && !sy_valid[base + w]) begin
				victim = w;
				found = 1;
			end
		if (!found)
			for (int w = 0; w < WAYS; w++)
				if (sy_rank[base + w] >= sy_rank[base + victim])
					victim = w;
		syn_promote(base, victim, sy_valid[base + victim]);
		sy_valid[base + victim] = 1'b1;
		sy_key[base + victim] = k;
		sy_start[base + victim] = now;
		sy_count[base + victim] = 33'd1;
		return 1'b0;
	endfunction

	function automatic out_t make_verdict(bit drop, logic [2:0] why, bit full);
		out_t v;
		v.drop = drop;
		v.reason = why;
		v.table_full = full;
		if (why <= R_MALFORMED) begin
			reason_cnt[why[1:0]] = reason_cnt[why[1:0]] + 64'd1;
			v.stat_value = reason_cnt[why[1:0]];
		end else begin
			v.stat_value = '0;
		end
		return v;
	endfunction

	function automatic out_t filter_verdict(in_t x);
		int e;
		int base;
		bit fin, syn, rst, psh, ack, urg, bad;
		if (x.operation == OP_ADD) begin
			e = bl_find(x.src_addr);
			if (e < 0) begin
				base = set_index(x.src_addr, BLK_N / WAYS) * WAYS;
				for (int w = 0; w < WAYS; w++)
					if (e < 0 && !bl_valid[base + w])
						e = base + w;
				if (e < 0)
					return make_verdict(0, R_UNCOUNTED, 1);
				bl_valid[e] = 1'b1;
				bl_key[e] = x.src_addr;
			end
			bl_exp[e] = x.ban_expiry_ns;
			return make_verdict(0, R_UNCOUNTED, 0);
		end
		if (x.operation == OP_REMOVE) begin
			e = bl_find(x.src_addr);
			if (e >= 0)
				bl_valid[e] = 1'b0;
			return make_verdict(0, R_UNCOUNTED, 0);
		end
		if (x.operation != OP_PACKET)
			return make_verdict(0, R_UNCOUNTED, 0);
		if (x.frame_len < 16'd34 || x.ethertype != ETHERTYPE_IPV4 || x.ip_ihl < MIN_HDR_WORDS)
			return make_verdict(0, R_UNCOUNTED, 0);
		e = bl_find(x.src_addr);
		if (e >= 0 && (bl_exp[e] == 0 || bl_exp[e] > x.now_ns))
			return make_verdict(1, R_BLOCK, 0);
		if (x.ip_protocol != PROTO_TCP)
			return make_verdict(0, R_PASS, 0);
		if ({1'b0, x.frame_len} < ETH_HDR_BYTES + {11'd0, x.ip_ihl, 2'b00} + TCP_HDR_BYTES)
			return make_verdict(1, R_MALFORMED, 0);
		if (prot_port == 0)
			return make_verdict(0, R_PASS, 0);
		if (x.tcp_dst_port == prot_port) begin
			fin = x.tcp_flag_bits[F_FIN];
			syn = x.tcp_flag_bits[F_SYN];
			rst = x.tcp_flag_bits[F_RST];
			psh = x.tcp_flag_bits[F_PSH];
			ack = x.tcp_flag_bits[F_ACK];
			urg = x.tcp_flag_bits[F_URG];
			bad = x.tcp_data_offset < MIN_HDR_WORDS || (!syn && !ack && !rst && !fin) ||
				(syn && fin) || (syn && rst) || (fin && psh && urg && !ack);
			if (bad || (syn && !ack && x.tcp_src_port < PRIV_PORT_LIMIT))
				return make_verdict(1, R_MALFORMED, 0);
			if (syn && !ack && syn_flooding(x.src_addr, x.now_ns))
				return make_verdict(1, R_FLOOD, 0);
		end
		return make_verdict(0, R_PASS, 0);
	endfunction

	// request accept and result check
	always @(posedge clk) begin
		out_t want;
		if (result_valid && result_ready) begin
			if (verdict_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result drop=%0b reason=%0d stat=%0d full=%0b",
						result.drop, result.reason, result.stat_value, result.table_full);
			end else begin
				want = verdict_q.pop_front();
				if (result !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp drop=%0b reason=%0d stat=%0d full=%0b / got drop=%0b reason=%0d stat=%0d full=%0b",
							want.drop, want.reason, want.stat_value, want.table_full,
							result.drop, result.reason, result.stat_value, result.table_full);
				end
			end
		end
		if (item_valid && item_ready) begin
			want = filter_verdict(item);
			if (row_typed)
				want = row_verdict;
			verdict_q.push_back(want);
		end
	end

	// result side stalls in bursts
	int stall_left;
	always @(posedge clk) begin
		if (quiet) begin
			result_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result_ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 9);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	task automatic send_request(in_t x, bit typed, out_t v);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= x;
		row_typed <= typed;
		row_verdict <= v;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		row_typed <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_config(logic [15:0] gp, logic [31:0] lim, logic [63:0] win);
		cfg_we <= 1'b1; cfg_index <= CFG_GAME_PORT; cfg_data <= {48'd0, gp};
		@(posedge clk);
		cfg_index <= CFG_SYN_LIMIT; cfg_data <= {32'd0, lim};
		@(posedge clk);
		cfg_index <= CFG_WINDOW; cfg_data <= win;
		@(posedge clk);
		cfg_we <= 1'b0;
		prot_port = gp;
		syn_limit = lim;
		win_len_ns = win;
	endtask

	function automatic in_t pkt(logic [1:0] op, logic [15:0] flen, logic [31:0] src,
			logic [5:0] flags, logic [3:0] doff, logic [15:0] sport, logic [63:0] now);
		in_t x;
		x = '0;
		x.operation = op;
		x.now_ns = now;
		x.frame_len = flen;
		x.ethertype = ETHERTYPE_IPV4;
		x.ip_ihl = 4'd5;
		x.ip_protocol = PROTO_TCP;
		x.src_addr = src;
		x.tcp_flag_bits = flags;
		x.tcp_data_offset = doff;
		x.tcp_src_port = sport;
		x.tcp_dst_port = prot_port;
		return x;
	endfunction

	function automatic in_t random_request();
		in_t x;
		int pick;
		logic [255:0] raw;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 99) == 0)
			now_clock = {$urandom, $urandom};
		else
			now_clock = now_clock + 64'($urandom_range(0, 400));
		x = pkt(OP_PACKET, 16'($urandom_range(54, 1500)), pool[$urandom_range(0, 11)],
			6'b000010, 4'd5, 16'($urandom_range(1024, 65535)), now_clock);
		if (pick < 8) begin
			raw = {$urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom};
			x = raw[$bits(in_t)-1:0];
			x.operation = 2'($urandom_range(0, 3));
		end else if (pick < 17) begin
			x.operation = OP_ADD;
			case ($urandom_range(0, 2))
				0: x.ban_expiry_ns = '0;
				1: x.ban_expiry_ns = now_clock + 64'($urandom_range(1, 3000));
				default: x.ban_expiry_ns = {$urandom, $urandom};
			endcase
		end else if (pick < 22) begin
			x.operation = OP_REMOVE;
		end else if (pick < 24) begin
			x.operation = 2'd3;
		end else begin
			if ($urandom_range(0, 9) == 0) x.ip_protocol = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 9) == 0) x.ip_ihl = 4'($urandom_range(0, 15));
			if ($urandom_range(0, 9) == 0) x.frame_len = 16'($urandom_range(0, 80));
			if ($urandom_range(0, 9) == 0) x.tcp_dst_port = 16'($urandom);
			if ($urandom_range(0, 5) == 0) x.tcp_flag_bits = 6'($urandom_range(0, 63));
			if ($urandom_range(0, 14) == 0) x.tcp_data_offset = 4'($urandom_range(0, 15));
			if ($urandom_range(0, 14) == 0) x.tcp_src_port = 16'($urandom_range(0, 2047));
			if ($urandom_range(0, 19) == 0) x.ethertype = 16'($urandom);
		end
		return x;
	endfunction

	initial begin
		in_t  rows [$];
		out_t typed_v [$];
		bit   typed [$];
		out_t pass_unc;
		out_t full_unc;
		logic [31:0] k;
		int n;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_GAME_PORT;
		cfg_data = '0;
		row_typed = 1'b0;
		row_verdict = '0;
		quiet = 1'b0;
		stall_left = 0;
		mismatches = 0;
		prot_port = '0;
		syn_limit = '0;
		win_len_ns = '0;
		now_clock = 64'd1000;
		for (int i = 0; i < 4; i++) reason_cnt[i] = '0;
		for (int i = 0; i < BLK_N; i++) bl_valid[i] = 0;
		for (int i = 0; i < SYN_N; i++) begin
			sy_valid[i] = 0;
			sy_rank[i] = 0;
		end
		// sources that share one blocklist set, hence one SYN set too
		n = 0;
		while (n < 12) begin
			k = $urandom;
			if (set_index(k, BLK_N / WAYS) == 17) begin
				pool[n] = k;
				n++;
			end
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		set_config(16'h04D2, 32'd2, 64'd1000);

		pass_unc = '{drop: 1'b0, reason: R_UNCOUNTED, stat_value: 64'd0, table_full: 1'b0};
		full_unc = pass_unc;
		full_unc.table_full = 1'b1;
		rows.push_back(pkt(OP_PACKET, 16'd0, pool[0], 6'h02, 4'd5, 16'd4000, 64'd100));
		rows.push_back(pkt(OP_PACKET, 16'd33, pool[0], 6'h02, 4'd5, 16'd4000, 64'd100));
		rows.push_back(pkt(OP_PACKET, 16'd60, pool[0], 6'h02, 4'd5, 16'd4000, 64'd100));
		rows[2].ethertype = 16'h86DD;
		rows.push_back(pkt(OP_PACKET, 16'd60, pool[0], 6'h02, 4'd5, 16'd4000, 64'd100));
		rows[3].ip_ihl = 4'd4;
		rows.push_back({$bits(in_t){1'b1}});
		rows.push_back(pkt(OP_ADD, 16'd0, pool[0], 6'h00, 4'd5, 16'd0, 64'd100));
		for (int i = 0; i < 6; i++) typed.push_back(1);
		rows.push_back(pkt(OP_PACKET, 16'd60, pool[0], 6'h10, 4'd5, 16'd4000, 64'd100));
		rows.push_back(pkt(OP_ADD, 16'd0, pool[0], 6'h00, 4'd5, 16'd0, 64'd100));
		rows[7].ban_expiry_ns = 64'd200;
		rows.push_back(pkt(OP_PACKET, 16'd60, pool[0], 6'h10, 4'd5, 16'd4000, 64'd199));
		rows.push_back(pkt(OP_PACKET, 16'd60, pool[0], 6'h10, 4'd5, 16'd4000, 64'd200));
		rows.push_back(pkt(OP_PACKET, 16'd60, pool[1], 6'h00, 4'd5, 16'd4000, 64'd200));
		rows[10].ip_protocol = 8'd17;
		rows.push_back(pkt(OP_PACKET, 16'd53, pool[1], 6'h10, 4'd5, 16'd4000, 64'd200));
		rows.push_back(pkt(OP_PACKET, 16'd60, pool[1], 6'h10, 4'd4, 16'd4000, 64'd200));
		rows.push_back(pkt(OP_PACKET, 16'd60, pool[1], 6'h00, 4'd5, 16'd4000, 64'd200));
		rows.push_back(pkt(OP_PACKET, 16'd60, pool[1], 6'h03, 4'd5, 16'd4000, 64'd200));
		rows.push_back(pkt(OP_PACKET, 16'd60, pool[1], 6'h06, 4'd5, 16'd4000, 64'd200));
		rows.push_back(pkt(OP_PACKET, 16'd60, pool[1], 6'h29, 4'd5, 16'd4000, 64'd200));
		rows.push_back(pkt(OP_PACKET, 16'd60, pool[1], 6'h02, 4'd5, 16'd1023, 64'd200));
		for (int i = 0; i < 3; i++)
			rows.push_back(pkt(OP_PACKET, 16'd60, pool[2], 6'h02, 4'd5, 16'd1024, 64'd300));
		rows.push_back(pkt(OP_PACKET, 16'd60, pool[2], 6'h02, 4'd5, 16'hFFFF, 64'd1301));
		for (int i = 0; i < 16; i++) typed.push_back(0);
		for (int i = 0; i < 4; i++)
			rows.push_back(pkt(OP_ADD, 16'd0, pool[3 + i], 6'h00, 4'd5, 16'd0, 64'd300));
		rows.push_back(pkt(OP_ADD, 16'd0, pool[7], 6'h00, 4'd5, 16'd0, 64'd300));
		rows.push_back(pkt(OP_REMOVE, 16'd0, pool[8], 6'h00, 4'd5, 16'd0, 64'd300));
		for (int i = 0; i < 4; i++) typed.push_back(0);
		typed.push_back(1);
		typed.push_back(1);
		for (int i = 0; i < rows.size(); i++) begin
			if (i == rows.size() - 2)
				send_request(rows[i], typed[i], full_unc);
			else
				send_request(rows[i], typed[i], pass_unc);
		end
		drain();

		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: set_config(16'd0, 32'd0, 64'd0);
				1: set_config(16'hFFFF, 32'd0, 64'd0);
				2: set_config(16'h04D2, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
				3: set_config(16'h04D2, 32'd3, 64'd500);
				4: set_config(16'($urandom_range(1, 65535)), 32'd1, 64'hFFFF_FFFF_FFFF_FFFF);
				5: set_config(16'h04D2, $urandom_range(0, 8), 64'($urandom_range(0, 5000)));
				default: begin
					set_config(16'h04D2, 32'd4, 64'd2000);
					quiet = 1'b1;
				end
			endcase
			repeat (200) send_request(random_request(), 1'b0, pass_unc);
			drain();
		end

		if (mismatches == 0 && verdict_q.size() == 0)
			$display("packet_blocklist_syn_rate_filter_tb: PASS");
		else
			$display("packet_blocklist_syn_rate_filter_tb: FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("packet_blocklist_syn_rate_filter_tb: FAIL");
		$finish;
	end

endmodule
